// ===== src/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, register and effect codes and color helpers for the LED
// pixel shader.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = 5;

  typedef enum logic [RegIdxW-1:0] {
    RegFgColor        = 3'd0,
    RegBgColor        = 3'd1,
    RegBgCode         = 3'd2,
    RegBrightness     = 3'd3,
    RegEffectMode     = 3'd4,
    RegGradientEnable = 3'd5,
    RegGradientMix    = 3'd6
  } lps_reg_e;

  typedef enum logic [2:0] {
    EffNone     = 3'd0,
    EffGradient = 3'd1,
    EffBreath   = 3'd2,
    EffFadeIn   = 3'd3,
    EffFadeOut  = 3'd4,
    EffCycle    = 3'd5
  } lps_effect_e;

  // color rotation selects
  localparam logic [1:0] RotNone = 2'd0;
  localparam logic [1:0] RotGbr  = 2'd1;
  localparam logic [1:0] RotBrg  = 2'd2;

  localparam logic [23:0] FgColorReset    = 24'hFFFFFF;
  localparam logic [23:0] BgColorReset    = 24'h000000;
  localparam logic [7:0]  BgCodeReset     = 8'd0;
  localparam logic [7:0]  BrightnessReset = 8'd255;
  localparam logic [2:0]  EffectReset     = 3'd1;
  localparam logic [7:0]  GradMixReset    = 8'd96;
  localparam logic [7:0]  BreathBase      = 8'd96;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } lps_rgb_t;

  typedef struct packed {
    logic       is_bg;
    lps_rgb_t   base;
    logic       grad_en;
    logic [7:0] grad_idx;
    logic       scale_en;
    logic [7:0] scale;
    logic [1:0] rot_sel;
  } lps_work_t;

  typedef struct packed {
    lps_rgb_t rgb;
    logic     is_bg;
  } lps_result_t;

  // 3-bit channel to 8 bits, c*255/7 truncated
  function automatic logic [7:0] expand3(input logic [2:0] c);
    logic [7:0] v;
    case (c)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd72;
      3'd3:    v = 8'd109;
      3'd4:    v = 8'd145;
      3'd5:    v = 8'd182;
      3'd6:    v = 8'd218;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // 2-bit channel to 8 bits, c*85
  function automatic logic [7:0] expand2(input logic [1:0] c);
    logic [7:0] v;
    case (c)
      2'd0:    v = 8'd0;
      2'd1:    v = 8'd85;
      2'd2:    v = 8'd170;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // exact x/255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== src/lps_fifo.sv =====
// ----------------------------------------------------------------------------
// lps_fifo
// Small first-in first-out queue in flops, used between the front and the
// back and in front of the result ports.
// ----------------------------------------------------------------------------
module lps_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lps_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !pop_i |=> !empty_o)
    else $error("queue empty after transfer in");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && !push_i && count_q == CntW'(1) |=> empty_o)
    else $error("queue not empty after last transfer out");
`endif

endmodule

// ===== src/lps_front.sv =====
// ----------------------------------------------------------------------------
// lps_front
// Input stage: takes a pixel, matches it against the background code,
// expands the 3-3-2 code and works out gradient index and effect controls.
// ----------------------------------------------------------------------------
module lps_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [7:0]         pixel_code_i,
  input  logic [7:0]         pixel_row_i,
  input  logic [7:0]         pixel_col_i,
  input  logic [7:0]         anim_phase_i,
  input  logic [23:0]        bg_color_i,
  input  logic [7:0]         bg_code_i,
  input  logic [2:0]         effect_mode_i,
  input  logic               gradient_enable_i,
  output logic               work_push_o,
  input  logic               work_full_i,
  output lps_pkg::lps_work_t work_o
);

  logic       valid_q, valid_d;
  logic [7:0] code_q, row_q, col_q, phase_q;
  logic       load;
  logic       is_bg;
  logic [4:0] ph;
  logic [3:0] breath_n;
  logic [7:0] breath_s;
  logic [3:0] mod_sum;
  logic [2:0] mod_red;
  logic [1:0] cycle_k;

  assign full_o      = valid_q & work_full_i;
  assign load        = push_i & ~full_o;
  assign work_push_o = valid_q & ~work_full_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (work_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q  <= pixel_code_i;
      row_q   <= pixel_row_i;
      col_q   <= pixel_col_i;
      phase_q <= anim_phase_i;
    end
  end

  assign is_bg = (code_q == bg_code_i);
  assign ph    = phase_q[4:0];

  // triangle wave over the low five phase bits
  assign breath_n = ph[4] ? ~ph[3:0] : ph[3:0];
  assign breath_s = lps_pkg::BreathBase + {1'b0, breath_n, 3'b000} + {3'b000, breath_n, 1'b0};

  // (phase >> 2) mod 3 from digit sums, 4 = 1 mod 3
  assign mod_sum = {2'b00, phase_q[3:2]} + {2'b00, phase_q[5:4]} + {2'b00, phase_q[7:6]};
  assign mod_red = {1'b0, mod_sum[3:2]} + {1'b0, mod_sum[1:0]};
  assign cycle_k = (mod_red >= 3'd3) ? 2'(mod_red - 3'd3) : mod_red[1:0];

  always_comb begin
    work_o.is_bg    = is_bg;
    work_o.grad_idx = {row_q[3:0], 4'h0} + col_q + {phase_q[5:0], 2'b00};
    work_o.grad_en  = ~is_bg & (gradient_enable_i ||
                      effect_mode_i == lps_pkg::EffGradient);
    work_o.scale_en = 1'b0;
    work_o.scale    = '0;
    work_o.rot_sel  = lps_pkg::RotNone;
    if (is_bg) begin
      work_o.base.r = bg_color_i[23:16];
      work_o.base.g = bg_color_i[15:8];
      work_o.base.b = bg_color_i[7:0];
    end else begin
      work_o.base.r = lps_pkg::expand3(code_q[7:5]);
      work_o.base.g = lps_pkg::expand3(code_q[4:2]);
      work_o.base.b = lps_pkg::expand2(code_q[1:0]);
      unique case (effect_mode_i)
        lps_pkg::EffBreath: begin
          work_o.scale_en = 1'b1;
          work_o.scale    = breath_s;
        end
        lps_pkg::EffFadeIn: begin
          work_o.scale_en = 1'b1;
          work_o.scale    = {ph, 3'b000};
        end
        lps_pkg::EffFadeOut: begin
          work_o.scale_en = 1'b1;
          work_o.scale    = ~{ph, 3'b000};
        end
        lps_pkg::EffCycle: begin
          work_o.rot_sel = cycle_k;
        end
        default: begin
          work_o.scale_en = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/lps_back.sv =====
// ----------------------------------------------------------------------------
// lps_back
// Five-stage color pipeline: tint, gradient products, gradient blend,
// effect scale or rotation, global brightness.
// ----------------------------------------------------------------------------
module lps_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 work_valid_i,
  input  lps_pkg::lps_work_t   work_i,
  output logic                 work_pop_o,
  input  logic [23:0]          fg_color_i,
  input  logic [7:0]           brightness_i,
  input  logic [7:0]           gradient_mix_i,
  output logic                 res_push_o,
  input  logic                 res_full_i,
  output lps_pkg::lps_result_t res_o
);

  logic               en;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  lps_pkg::lps_work_t w1_q, w2_q, w3_q;
  logic               bg4_q, bg5_q;
  lps_pkg::lps_rgb_t  c1_q, c2_q, c3_q, c4_q, c5_q;
  lps_pkg::lps_rgb_t  c1_d, c3_d, c4_d, c5_d, grad;
  logic [15:0]        pp_r_q, pp_g_q, pp_b_q;
  logic [15:0]        pg_r_q, pg_g_q, pg_b_q;
  logic [7:0]         inv_mix;
  lps_pkg::lps_rgb_t  scaled;

  // whole pipe holds only when the last stage cannot hand off
  assign en         = ~(v5_q & res_full_i);
  assign work_pop_o = en & work_valid_i;
  assign res_push_o = v5_q & ~res_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= work_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // tint
  always_comb begin
    if (work_i.is_bg) begin
      c1_d = work_i.base;
    end else begin
      c1_d.r = lps_pkg::div255(16'(work_i.base.r) * 16'(fg_color_i[23:16]));
      c1_d.g = lps_pkg::div255(16'(work_i.base.g) * 16'(fg_color_i[15:8]));
      c1_d.b = lps_pkg::div255(16'(work_i.base.b) * 16'(fg_color_i[7:0]));
    end
  end

  // gradient color and blend weights
  assign inv_mix = ~gradient_mix_i;
  assign grad.r  = w1_q.grad_idx;
  assign grad.g  = ~w1_q.grad_idx;
  assign grad.b  = {1'b0, w1_q.grad_idx[7:1]};

  // blend
  assign c3_d.r = w2_q.grad_en ? lps_pkg::div255(pp_r_q + pg_r_q) : c2_q.r;
  assign c3_d.g = w2_q.grad_en ? lps_pkg::div255(pp_g_q + pg_g_q) : c2_q.g;
  assign c3_d.b = w2_q.grad_en ? lps_pkg::div255(pp_b_q + pg_b_q) : c2_q.b;

  // effect
  assign scaled.r = lps_pkg::div255(16'(c3_q.r) * 16'(w3_q.scale));
  assign scaled.g = lps_pkg::div255(16'(c3_q.g) * 16'(w3_q.scale));
  assign scaled.b = lps_pkg::div255(16'(c3_q.b) * 16'(w3_q.scale));

  always_comb begin
    if (w3_q.scale_en) begin
      c4_d = scaled;
    end else begin
      case (w3_q.rot_sel)
        lps_pkg::RotGbr: c4_d = '{r: c3_q.g, g: c3_q.b, b: c3_q.r};
        lps_pkg::RotBrg: c4_d = '{r: c3_q.b, g: c3_q.r, b: c3_q.g};
        default:         c4_d = c3_q;
      endcase
    end
  end

  // brightness
  assign c5_d.r = lps_pkg::div255(16'(c4_q.r) * 16'(brightness_i));
  assign c5_d.g = lps_pkg::div255(16'(c4_q.g) * 16'(brightness_i));
  assign c5_d.b = lps_pkg::div255(16'(c4_q.b) * 16'(brightness_i));

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q   <= work_i;
      c1_q   <= c1_d;
      w2_q   <= w1_q;
      c2_q   <= c1_q;
      pp_r_q <= 16'(c1_q.r) * 16'(inv_mix);
      pp_g_q <= 16'(c1_q.g) * 16'(inv_mix);
      pp_b_q <= 16'(c1_q.b) * 16'(inv_mix);
      pg_r_q <= 16'(grad.r) * 16'(gradient_mix_i);
      pg_g_q <= 16'(grad.g) * 16'(gradient_mix_i);
      pg_b_q <= 16'(grad.b) * 16'(gradient_mix_i);
      w3_q   <= w2_q;
      c3_q   <= c3_d;
      bg4_q  <= w3_q.is_bg;
      c4_q   <= c4_d;
      bg5_q  <= bg4_q;
      c5_q   <= c5_d;
    end
  end

  assign res_o.rgb   = c5_q;
  assign res_o.is_bg = bg5_q;

`ifndef ASSERT_OFF
  a_pop_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_pop_o |=> v1_q)
    else $error("transfer from queue lost at first stage");

  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && res_full_i |=> v5_q && $stable(c5_q) && $stable(bg5_q))
    else $error("stalled result changed");

  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && res_full_i |-> !work_pop_o && !res_push_o)
    else $error("transfer while pipe stalled");
`endif

endmodule

// ===== src/led_pixel_shader_core.sv =====
// ----------------------------------------------------------------------------
// led_pixel_shader_core
// Path: front register, work queue, five color stages, result queue.
// Throughput: one pixel per cycle while the result queue is not full.
// Reset: queues and pipeline empty, registers at their documented defaults.
// ----------------------------------------------------------------------------
module led_pixel_shader_core #(
  parameter int unsigned QueueDepth = lps_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lps_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                pixel_code_i,
  input  logic [7:0]                pixel_row_i,
  input  logic [7:0]                pixel_col_i,
  input  logic [7:0]                anim_phase_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                red_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                blue_out_o,
  output logic                      is_background_o
);

  localparam int unsigned WorkW = $bits(lps_pkg::lps_work_t);
  localparam int unsigned ResW  = $bits(lps_pkg::lps_result_t);

  logic [23:0] fg_color_q, bg_color_q;
  logic [7:0]  bg_code_q, brightness_q, gradient_mix_q;
  logic [2:0]  effect_mode_q;
  logic        gradient_enable_q;
  logic        cfg_wr;
  logic [lps_pkg::RegIdxW-1:0] reg_idx;

  lps_pkg::lps_work_t   front_work, back_work;
  lps_pkg::lps_result_t back_res, out_res;
  logic [WorkW-1:0]     back_work_bits;
  logic [ResW-1:0]      out_res_bits;
  logic                 work_push, work_full, work_empty, work_pop;
  logic                 res_push, res_full;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[lps_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q        <= lps_pkg::FgColorReset;
      bg_color_q        <= lps_pkg::BgColorReset;
      bg_code_q         <= lps_pkg::BgCodeReset;
      brightness_q      <= lps_pkg::BrightnessReset;
      effect_mode_q     <= lps_pkg::EffectReset;
      gradient_enable_q <= 1'b0;
      gradient_mix_q    <= lps_pkg::GradMixReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lps_pkg::RegFgColor:        fg_color_q        <= pwdata[23:0];
        lps_pkg::RegBgColor:        bg_color_q        <= pwdata[23:0];
        lps_pkg::RegBgCode:         bg_code_q         <= pwdata[7:0];
        lps_pkg::RegBrightness:     brightness_q      <= pwdata[7:0];
        lps_pkg::RegEffectMode:     effect_mode_q     <= pwdata[2:0];
        lps_pkg::RegGradientEnable: gradient_enable_q <= pwdata[0];
        lps_pkg::RegGradientMix:    gradient_mix_q    <= pwdata[7:0];
        default:                    fg_color_q        <= fg_color_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lps_pkg::RegFgColor:        prdata = {8'd0, fg_color_q};
      lps_pkg::RegBgColor:        prdata = {8'd0, bg_color_q};
      lps_pkg::RegBgCode:         prdata = {24'd0, bg_code_q};
      lps_pkg::RegBrightness:     prdata = {24'd0, brightness_q};
      lps_pkg::RegEffectMode:     prdata = {29'd0, effect_mode_q};
      lps_pkg::RegGradientEnable: prdata = {31'd0, gradient_enable_q};
      lps_pkg::RegGradientMix:    prdata = {24'd0, gradient_mix_q};
      default:                    prdata = '0;
    endcase
  end

  lps_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .pixel_code_i      (pixel_code_i),
    .pixel_row_i       (pixel_row_i),
    .pixel_col_i       (pixel_col_i),
    .anim_phase_i      (anim_phase_i),
    .bg_color_i        (bg_color_q),
    .bg_code_i         (bg_code_q),
    .effect_mode_i     (effect_mode_q),
    .gradient_enable_i (gradient_enable_q),
    .work_push_o       (work_push),
    .work_full_i       (work_full),
    .work_o            (front_work)
  );

  lps_fifo #(
    .Width (WorkW),
    .Depth (QueueDepth)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_push),
    .full_o  (work_full),
    .data_i  (front_work),
    .pop_i   (work_pop),
    .empty_o (work_empty),
    .data_o  (back_work_bits)
  );

  assign back_work = lps_pkg::lps_work_t'(back_work_bits);

  lps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .work_valid_i   (~work_empty),
    .work_i         (back_work),
    .work_pop_o     (work_pop),
    .fg_color_i     (fg_color_q),
    .brightness_i   (brightness_q),
    .gradient_mix_i (gradient_mix_q),
    .res_push_o     (res_push),
    .res_full_i     (res_full),
    .res_o          (back_res)
  );

  lps_fifo #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (back_res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_res_bits)
  );

  assign out_res         = lps_pkg::lps_result_t'(out_res_bits);
  assign red_out_o       = out_res.rgb.r;
  assign green_out_o     = out_res.rgb.g;
  assign blue_out_o      = out_res.rgb.b;
  assign is_background_o = out_res.is_bg;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED pixel shader. A queue-fed driver pushes
// RGB332 pixels with random gaps and a monitor pops shaded colors with
// random stalls. Each color is checked against a local color predictor.
// Registers are rewritten and read back between bursts over the APB port.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned LongHold   = 120;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned BurstLen   = 150;
  localparam int unsigned NumBursts  = 12;
  localparam int unsigned MaxPrints  = 40;
  localparam logic [lps_pkg::RegIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] phase;
  } pixel_req_t;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [lps_pkg::AddrW-1:0] paddr = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push         = 1'b0;
  logic              full;
  logic [7:0]        pixel_code_i = '0;
  logic [7:0]        pixel_row_i  = '0;
  logic [7:0]        pixel_col_i  = '0;
  logic [7:0]        anim_phase_i = '0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [7:0]        red_out_o;
  logic [7:0]        green_out_o;
  logic [7:0]        blue_out_o;
  logic              is_background_o;

  // register copies used by the color predictor
  logic [23:0] fg_color_q   = lps_pkg::FgColorReset;
  logic [23:0] bg_color_q   = lps_pkg::BgColorReset;
  logic [7:0]  bg_code_q    = lps_pkg::BgCodeReset;
  logic [7:0]  bright_q     = lps_pkg::BrightnessReset;
  logic [2:0]  effect_q     = lps_pkg::EffectReset;
  logic        grad_en_q    = 1'b0;
  logic [7:0]  grad_mix_q   = lps_pkg::GradMixReset;

  pixel_req_t           pixel_q[$];
  lps_pkg::lps_result_t pending_colors_q[$];

  logic        idle_en      = 1'b1;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_gap       = 0;
  int unsigned rx_hold      = 0;
  int unsigned max_hold     = 0;
  int unsigned full_stalls  = 0;
  int unsigned stuck_cycles = 0;
  int unsigned err_cnt      = 0;
  int unsigned n_px         = 0;
  int unsigned n_bg         = 0;
  int unsigned n_cfg        = 0;

  led_pixel_shader_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .pixel_code_i   (pixel_code_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_col_i    (pixel_col_i),
    .anim_phase_i   (anim_phase_i),
    .empty          (empty),
    .pop            (pop),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .is_background_o(is_background_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrints) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  function automatic lps_pkg::lps_result_t shade_pixel(input pixel_req_t px);
    int unsigned ch[3];
    int unsigned grad[3];
    int unsigned m, a, s, p, k, t0, t1, t2;
    lps_pkg::lps_result_t res;
    res.is_bg = (px.code == bg_code_q);
    if (res.is_bg) begin
      ch[0] = bg_color_q[23:16];
      ch[1] = bg_color_q[15:8];
      ch[2] = bg_color_q[7:0];
    end else begin
      // 3-3-2 expansion, then foreground tint
      ch[0] = px.code[7:5] * 255 / 7;
      ch[1] = px.code[4:2] * 255 / 7;
      ch[2] = px.code[1:0] * 255 / 3;
      ch[0] = ch[0] * fg_color_q[23:16] / 255;
      ch[1] = ch[1] * fg_color_q[15:8] / 255;
      ch[2] = ch[2] * fg_color_q[7:0] / 255;
      if (grad_en_q || effect_q == lps_pkg::EffGradient) begin
        m = (px.row * 16 + px.col + px.phase * 4) % 256;
        grad[0] = m;
        grad[1] = 255 - m;
        grad[2] = m >> 1;
        a = grad_mix_q;
        for (int i = 0; i < 3; i++) ch[i] = (ch[i] * (255 - a) + grad[i] * a) / 255;
      end
      p = px.phase[4:0];
      s = 255;
      case (effect_q)
        lps_pkg::EffBreath: begin
          s = (p < 16) ? lps_pkg::BreathBase + 10 * p
                       : lps_pkg::BreathBase + 10 * (31 - p);
        end
        lps_pkg::EffFadeIn:  s = 8 * p;
        lps_pkg::EffFadeOut: s = 255 - 8 * p;
        lps_pkg::EffCycle: begin
          k  = px.phase[7:2] % 3;
          t0 = ch[0];
          t1 = ch[1];
          t2 = ch[2];
          if (k == lps_pkg::RotGbr) begin
            ch[0] = t1; ch[1] = t2; ch[2] = t0;
          end else if (k == lps_pkg::RotBrg) begin
            ch[0] = t2; ch[1] = t0; ch[2] = t1;
          end
        end
        default: ;
      endcase
      if (effect_q inside {lps_pkg::EffBreath, lps_pkg::EffFadeIn, lps_pkg::EffFadeOut}) begin
        for (int i = 0; i < 3; i++) ch[i] = ch[i] * s / 255;
      end
    end
    for (int i = 0; i < 3; i++) ch[i] = ch[i] * bright_q / 255;
    res.rgb.r = ch[0][7:0];
    res.rgb.g = ch[1][7:0];
    res.rgb.b = ch[2][7:0];
    return res;
  endfunction

  // pixel driver: holds an item until it is transferred
  always @(posedge clk_i) begin
    lps_pkg::lps_result_t shade;
    pixel_req_t           nxt;
    if (rst_ni) begin
      if (push && full) full_stalls++;
      if (push && !full) begin
        shade = shade_pixel({pixel_code_i, pixel_row_i, pixel_col_i, anim_phase_i});
        pending_colors_q.push_back(shade);
        n_px++;
        if (shade.is_bg) n_bg++;
      end
      if (!(push && full)) begin
        if (tx_gap == 0 && idle_en && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 12);
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          push         <= 1'b1;
          pixel_code_i <= nxt.code;
          pixel_row_i  <= nxt.row;
          pixel_col_i  <= nxt.col;
          anim_phase_i <= nxt.phase;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // color monitor and receiver stalls
  always @(posedge clk_i) begin
    lps_pkg::lps_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_colors_q.size() == 0) begin
          report_mismatch("color transfer with nothing expected");
        end else begin
          want = pending_colors_q.pop_front();
          check_field("red", want.rgb.r, red_out_o);
          check_field("green", want.rgb.g, green_out_o);
          check_field("blue", want.rgb.b, blue_out_o);
          check_field("is_background", {7'd0, want.is_bg}, {7'd0, is_background_o});
        end
      end
      if (hold_ack_cnt != hold_req_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        rx_hold      = LongHold;
        max_hold     = LongHold;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer while work is outstanding
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) ||
        (pixel_q.size() == 0 && !push && pending_colors_q.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StallLimit) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, stuck_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (!(pixel_q.size() == 0 && !push && pending_colors_q.size() == 0));
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [lps_pkg::RegIdxW-1:0] idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [23:0] fg, input logic [23:0] bg,
                            input logic [7:0] code, input logic [7:0] bright,
                            input logic [2:0] eff, input logic gen, input logic [7:0] mix);
    logic [31:0] rd;
    logic [31:0] want;
    drain();
    apb_xfer(1'b1, lps_pkg::RegFgColor, {8'd0, fg}, rd);
    apb_xfer(1'b1, lps_pkg::RegBgColor, {8'd0, bg}, rd);
    apb_xfer(1'b1, lps_pkg::RegBgCode, {24'd0, code}, rd);
    apb_xfer(1'b1, lps_pkg::RegBrightness, {24'd0, bright}, rd);
    apb_xfer(1'b1, lps_pkg::RegEffectMode, {29'd0, eff}, rd);
    apb_xfer(1'b1, lps_pkg::RegGradientEnable, {31'd0, gen}, rd);
    apb_xfer(1'b1, lps_pkg::RegGradientMix, {24'd0, mix}, rd);
    fg_color_q = fg;
    bg_color_q = bg;
    bg_code_q  = code;
    bright_q   = bright;
    effect_q   = eff;
    grad_en_q  = gen;
    grad_mix_q = mix;
    n_cfg++;
    for (int i = 0; i <= lps_pkg::RegGradientMix; i++) begin
      apb_xfer(1'b0, i[lps_pkg::RegIdxW-1:0], 32'd0, rd);
      case (lps_pkg::lps_reg_e'(i))
        lps_pkg::RegFgColor:        want = {8'd0, fg_color_q};
        lps_pkg::RegBgColor:        want = {8'd0, bg_color_q};
        lps_pkg::RegBgCode:         want = {24'd0, bg_code_q};
        lps_pkg::RegBrightness:     want = {24'd0, bright_q};
        lps_pkg::RegEffectMode:     want = {29'd0, effect_q};
        lps_pkg::RegGradientEnable: want = {31'd0, grad_en_q};
        default:                    want = {24'd0, grad_mix_q};
      endcase
      if (rd !== want) report_mismatch($sformatf("register %0d reads %h, want %h", i, rd, want));
    end
  endtask

  task automatic queue_px(input logic [7:0] code, input logic [7:0] row,
                          input logic [7:0] col, input logic [7:0] phase);
    pixel_q.push_back({code, row, col, phase});
  endtask

  task automatic queue_random(input int unsigned n);
    logic [7:0] code;
    for (int i = 0; i < n; i++) begin
      code = ($urandom_range(0, 7) == 0) ? bg_code_q : 8'($urandom);
      queue_px(code, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] rd;
    logic [23:0] fg;
    logic [7:0]  bright;
    logic [7:0]  mix;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: gradient effect, full brightness
    queue_px(8'h00, 8'h00, 8'h00, 8'h00);
    queue_px(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_px(8'h01, 8'h00, 8'h00, 8'h00);
    queue_px(8'h80, 8'h7F, 8'h80, 8'h7F);

    // breath ramps up to phase 15 and back down from 16
    set_config(24'hFFFFFF, 24'hA5C3F0, 8'h5A, 8'd255, lps_pkg::EffBreath, 1'b0, 8'd0);
    // an unmapped register index must leave everything alone
    apb_xfer(1'b1, RegUnused, $urandom, rd);
    queue_px(8'h5A, 8'h10, 8'h20, 8'h03);
    queue_px(8'hFF, 8'h00, 8'h00, 8'd0);
    queue_px(8'hFF, 8'h00, 8'h00, 8'd15);
    queue_px(8'hFF, 8'h00, 8'h00, 8'd16);
    queue_px(8'hFF, 8'h00, 8'h00, 8'd31);

    set_config(24'hFFFFFF, 24'hA5C3F0, 8'h5A, 8'd128, lps_pkg::EffFadeIn, 1'b0, 8'd0);
    queue_px(8'hFF, 8'h01, 8'h02, 8'd0);
    queue_px(8'hFF, 8'h01, 8'h02, 8'd31);

    set_config(24'hFFFFFF, 24'hA5C3F0, 8'h5A, 8'd128, lps_pkg::EffFadeOut, 1'b0, 8'd0);
    queue_px(8'hFF, 8'h01, 8'h02, 8'd0);
    queue_px(8'hFF, 8'h01, 8'h02, 8'd31);

    // rotation selects: phase>>2 mod 3 gives none, gbr, brg
    set_config(24'hFFFFFF, 24'h000000, 8'h00, 8'd255, lps_pkg::EffCycle, 1'b0, 8'd0);
    queue_px(8'hE3, 8'h00, 8'h00, 8'd0);
    queue_px(8'hE3, 8'h00, 8'h00, 8'd4);
    queue_px(8'hE3, 8'h00, 8'h00, 8'd8);

    // unused effect codes, gradient forced on and off
    set_config(24'h80FF40, 24'h123456, 8'hFF, 8'd255, 3'd6, 1'b1, 8'd255);
    queue_px(8'h6D, 8'h0F, 8'hF0, 8'h55);
    queue_px(8'hFF, 8'h0F, 8'hF0, 8'h55);
    set_config(24'h80FF40, 24'h123456, 8'hFF, 8'd255, 3'd7, 1'b0, 8'd255);
    queue_px(8'h6D, 8'h0F, 8'hF0, 8'h55);
    set_config(24'h80FF40, 24'h123456, 8'hFF, 8'd200, lps_pkg::EffNone, 1'b1, 8'd64);
    queue_px(8'h92, 8'hAA, 8'h55, 8'hC3);

    for (int ph = 0; ph < NumBursts; ph++) begin
      case (ph % 3)
        0:       fg = 24'hFFFFFF;
        1:       fg = (ph == 1) ? 24'h000000 : 24'($urandom);
        default: fg = 24'($urandom);
      endcase
      bright = (ph == 1) ? 8'd0 : ((ph % 4 == 0) ? 8'd255 : 8'($urandom));
      mix    = (ph == 2) ? 8'd0 : ((ph == 5) ? 8'd255 : 8'($urandom));
      set_config(fg, 24'($urandom), 8'($urandom), bright, 3'(ph % 8),
                 1'($urandom_range(0, 1)), mix);
      // no idling in some bursts and none at all near the end
      idle_en <= (ph < NumBursts - 3) && (ph % 3 != 1);
      if (ph == 3) hold_req_cnt <= hold_req_cnt + 1;
      if (ph == 5) begin
        queue_random(BurstLen / 2);
        drain();
        queue_random(BurstLen - BurstLen / 2);
      end else begin
        queue_random(BurstLen);
      end
    end

    drain();
    $display("checked %0d pixels (%0d background) under %0d register settings, all effect codes",
             n_px, n_bg, n_cfg);
    $display("input stalled by a full block on %0d cycles, longest receiver hold %0d cycles",
             full_stalls, max_hold);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== led_pixel_shader_core.f =====
src/lps_pkg.sv
src/lps_fifo.sv
src/lps_front.sv
src/lps_back.sv
src/led_pixel_shader_core.sv
sim/tb_top.sv
